// ===== hw/rtl/humidity_temp_frame_decoder_core_assert.svh =====
// Assertion macros shared by the frame decoder RTL.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HMTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hmtd assertion failed");

// Next-cycle implication, checked out of reset.
`define HMTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hmtd assertion failed");

`endif

// ===== hw/rtl/hmtd_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the frame decoder.
// No dependencies.
package hmtd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int FIFO_DEPTH = 2;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  // Classified frame handed from front to back.
  typedef struct packed {
    logic        good;
    logic        temp_crc_ok;
    logic        hum_crc_ok;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
  } frame_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/hmtd_front.sv =====
// Front end: accepts frames, runs both CRC-8 checks split around the stage register
// (high byte at input, low byte from the stage register) and classifies.
// Depends on hmtd_pkg.
module hmtd_front import hmtd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        transfer_ok_i,
  input  logic [15:0] temperature_word_i,
  input  logic [7:0]  temperature_check_i,
  input  logic [15:0] humidity_word_i,
  input  logic [7:0]  humidity_check_i,
  output logic        push_o,
  output frame_t      frame_o,
  input  logic        full_i
);

  logic        f_valid_q;
  logic        f_ok_q;
  logic [15:0] f_tword_q;
  logic [15:0] f_hword_q;
  logic [7:0]  f_tchk_q;
  logic [7:0]  f_hchk_q;
  logic [7:0]  f_tcrc_hi_q;
  logic [7:0]  f_hcrc_hi_q;
  logic        accept;
  logic [7:0]  tcrc;
  logic [7:0]  hcrc;
  logic        tcrc_ok;
  logic        hcrc_ok;

  assign in_ready_o = !f_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = f_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (accept) begin
      f_valid_q <= 1'b1;
    end else if (push_o) begin
      f_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_ok_q      <= transfer_ok_i;
      f_tword_q   <= temperature_word_i;
      f_hword_q   <= humidity_word_i;
      f_tchk_q    <= temperature_check_i;
      f_hchk_q    <= humidity_check_i;
      f_tcrc_hi_q <= crc8_byte(CRC_INIT, temperature_word_i[15:8]);
      f_hcrc_hi_q <= crc8_byte(CRC_INIT, humidity_word_i[15:8]);
    end
  end

  assign tcrc    = crc8_byte(f_tcrc_hi_q, f_tword_q[7:0]);
  assign hcrc    = crc8_byte(f_hcrc_hi_q, f_hword_q[7:0]);
  // no check counts on a failed transfer
  assign tcrc_ok = f_ok_q && (tcrc == f_tchk_q);
  assign hcrc_ok = f_ok_q && (hcrc == f_hchk_q);

  always_comb begin
    frame_o.good        = tcrc_ok && hcrc_ok;
    frame_o.temp_crc_ok = tcrc_ok;
    frame_o.hum_crc_ok  = hcrc_ok;
    frame_o.temp_word   = f_tword_q;
    frame_o.hum_word    = f_hword_q;
  end

endmodule

// ===== hw/rtl/hmtd_fifo.sv =====
// Small queue of classified frames between front and back.
// Depends on hmtd_pkg.
module hmtd_fifo import hmtd_pkg::*; #(
  parameter int Depth = FIFO_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t din_i,
  output logic   full_o,
  input  logic   pop_i,
  output frame_t dout_o,
  output logic   empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// ===== hw/rtl/hmtd_back.sv =====
// Back end: scales raw words (multiply stage, then divide-by-65535 and offset
// stage), keeps the last good reading and drives the output register.
// Depends on hmtd_pkg.
module hmtd_back import hmtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frame_t             frame_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_valid_o,
  output logic               healthy_o,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_pct_o,
  output logic               temperature_crc_ok_o,
  output logic               humidity_crc_ok_o
);

  logic               adv;
  logic               b_valid_q;
  logic               b_good_q;
  logic               b_tcrc_q;
  logic               b_hcrc_q;
  logic [30:0]        b_tprod_q;
  logic [29:0]        b_hprod_q;
  logic [31:0]        tsum;
  logic [30:0]        hsum;
  logic [14:0]        tquot;
  logic [13:0]        hquot;
  logic [15:0]        tdiff;
  logic [13:0]        hum_fresh;
  logic [14:0]        temp_fresh;
  logic               out_valid_q;
  logic               sample_valid_q;
  logic               healthy_q;
  logic [14:0]        temp_q;
  logic [13:0]        hum_q;
  logic               tcrc_q;
  logic               hcrc_q;
  logic [14:0]        held_temp_q;
  logic [13:0]        held_hum_q;
  logic               have_q;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_good_q  <= frame_i.good;
      b_tcrc_q  <= frame_i.temp_crc_ok;
      b_hcrc_q  <= frame_i.hum_crc_ok;
      b_tprod_q <= 31'(TEMP_SCALE) * 31'(frame_i.temp_word);
      b_hprod_q <= 30'(HUM_SCALE) * 30'(frame_i.hum_word);
    end
  end

  // floor(x / 65535) == (x + (x >> 16) + 1) >> 16 while the quotient <= 65536
  assign tsum  = 32'(b_tprod_q) + 32'(b_tprod_q[30:16]) + 32'd1;
  assign hsum  = 31'(b_hprod_q) + 31'(b_hprod_q[29:16]) + 31'd1;
  assign tquot = tsum[30:16];
  assign hquot = hsum[29:16];

  assign tdiff      = {1'b0, tquot} - TEMP_OFFSET;
  assign temp_fresh = tdiff[14:0];

  always_comb begin
    if (hquot < HUM_OFFSET) begin
      hum_fresh = '0;
    end else if (hquot > (HUM_MAX + HUM_OFFSET)) begin
      hum_fresh = HUM_MAX;
    end else begin
      hum_fresh = hquot - HUM_OFFSET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      held_temp_q <= '0;
      held_hum_q  <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= b_valid_q;
      end
      if (adv && b_valid_q && b_good_q) begin
        have_q      <= 1'b1;
        held_temp_q <= temp_fresh;
        held_hum_q  <= hum_fresh;
      end
    end
  end

  // held regs stay zero until the first good frame, so no-sample reads zero
  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q) begin
      sample_valid_q <= have_q || b_good_q;
      healthy_q      <= b_good_q;
      temp_q         <= b_good_q ? temp_fresh : held_temp_q;
      hum_q          <= b_good_q ? hum_fresh : held_hum_q;
      tcrc_q         <= b_tcrc_q;
      hcrc_q         <= b_hcrc_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign sample_valid_o       = sample_valid_q;
  assign healthy_o            = healthy_q;
  assign temperature_centi_o  = $signed(temp_q);
  assign humidity_centi_pct_o = hum_q;
  assign temperature_crc_ok_o = tcrc_q;
  assign humidity_crc_ok_o    = hcrc_q;

endmodule

// ===== hw/rtl/humidity_temp_frame_decoder_core.sv =====
// out_valid_o follows the front stage, queue, back multiply and output registers;
// the result beat is the next edge with out_ready_i high. Throughput: one frame
// per cycle unless out_ready_i stalls; the front CRC stage, the queue and the
// two-stage back pipeline (multiply, then divide/offset) each move a beat a cycle.
// Reset (rst_ni, async, active low): channels empty, queue empty, no reading
// held, so the first frames report no sample until a good one arrives.
module humidity_temp_frame_decoder_core import hmtd_pkg::*; #(
  parameter int FifoDepth = FIFO_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               transfer_ok_i,
  input  logic [15:0]        temperature_word_i,
  input  logic [7:0]         temperature_check_i,
  input  logic [15:0]        humidity_word_i,
  input  logic [7:0]         humidity_check_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_valid_o,
  output logic               healthy_o,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_pct_o,
  output logic               temperature_crc_ok_o,
  output logic               humidity_crc_ok_o
);

  `include "humidity_temp_frame_decoder_core_assert.svh"

  logic   push;
  logic   full;
  logic   pop;
  logic   empty;
  frame_t push_frame;
  frame_t pop_frame;

  hmtd_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .transfer_ok_i       (transfer_ok_i),
    .temperature_word_i  (temperature_word_i),
    .temperature_check_i (temperature_check_i),
    .humidity_word_i     (humidity_word_i),
    .humidity_check_i    (humidity_check_i),
    .push_o              (push),
    .frame_o             (push_frame),
    .full_i              (full)
  );

  hmtd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (push_frame),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (pop_frame),
    .empty_o (empty)
  );

  hmtd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .frame_i              (pop_frame),
    .empty_i              (empty),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .sample_valid_o       (sample_valid_o),
    .healthy_o            (healthy_o),
    .temperature_centi_o  (temperature_centi_o),
    .humidity_centi_pct_o (humidity_centi_pct_o),
    .temperature_crc_ok_o (temperature_crc_ok_o),
    .humidity_crc_ok_o    (humidity_crc_ok_o)
  );

  `HMTD_ASSERT_IMP(a_healthy_implies_checks, out_valid_o && healthy_o,
                   sample_valid_o && temperature_crc_ok_o && humidity_crc_ok_o)
  `HMTD_ASSERT_IMP(a_no_sample_zero, out_valid_o && !sample_valid_o,
                   temperature_centi_o == 15'sd0 && humidity_centi_pct_o == 14'd0)
  `HMTD_ASSERT_IMP(a_ranges, out_valid_o,
                   humidity_centi_pct_o <= HUM_MAX && temperature_centi_o >= -15'sd4500)
  `HMTD_ASSERT_NEXT(a_reading_sticks, out_valid_o && sample_valid_o,
                    !out_valid_o || sample_valid_o)

endmodule
